@@ hdl/psf_pkg.sv @@
// ---------------------------------------------------------------------------
// psf_pkg: shared types and constants of the particle selection filter
// Register indexes, filter mode codes, field widths, the configuration
// struct and the type-mask test.
// ---------------------------------------------------------------------------
`default_nettype none

package psf_pkg;

  localparam int unsigned IdW     = 24;
  localparam int unsigned TypeW   = 9;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ScalarW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned RadiusW = 36;

  // difference of two coordinates, product and three-term sum
  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned SumW  = ProdW + 3;

  // filter modes
  localparam logic [2:0] ModeTrivial  = 3'd0;
  localparam logic [2:0] ModeTypeMask = 3'd1;
  localparam logic [2:0] ModePlane    = 3'd2;
  localparam logic [2:0] ModeInterval = 3'd3;
  localparam logic [2:0] ModeSphere   = 3'd4;

  // interval attribute selects
  localparam logic [2:0] AttrPosX   = 3'd0;
  localparam logic [2:0] AttrPosY   = 3'd1;
  localparam logic [2:0] AttrPosZ   = 3'd2;
  localparam logic [2:0] AttrVelX   = 3'd3;
  localparam logic [2:0] AttrVelY   = 3'd4;
  localparam logic [2:0] AttrVelZ   = 3'd5;
  localparam logic [2:0] AttrSpeed2 = 3'd6;
  localparam logic [2:0] AttrScalar = 3'd7;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegFilterMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegControlFlags = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTypeFlags    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntervalAttr = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRefPoint     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNormalVector = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRadiusSq     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegIntervalBnd  = 3'd7;

  // type_flags bits
  localparam int unsigned TfAllBaryon = 0;
  localparam int unsigned TfAllDm     = 1;
  localparam int unsigned TfStar      = 2;
  localparam int unsigned TfWind      = 3;
  localparam int unsigned TfGas       = 4;
  localparam int unsigned TfNucleus   = 5;

  // type_bits bits
  localparam int unsigned TbBaryon  = 1;
  localparam int unsigned TbStar    = 5;
  localparam int unsigned TbWind    = 6;
  localparam int unsigned TbGas     = 7;
  localparam int unsigned TbNucleus = 8;

  localparam logic signed [ScalarW-1:0] Speed2Max = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [2:0]                 filter_mode;
    logic                       and_mode;
    logic                       invert;
    logic [5:0]                 type_flags;
    logic [2:0]                 interval_attr;
    logic [3*CoordW-1:0]        ref_point;
    logic [3*CoordW-1:0]        normal_vector;
    logic [RadiusW-1:0]         radius_sq;
    logic signed [ScalarW-1:0]  interval_lo;
    logic signed [ScalarW-1:0]  interval_hi;
  } cfg_t;

  function automatic logic type_hit(input logic [5:0] flags, input logic [TypeW-1:0] t);
    logic sel_hit;
    logic res;
    sel_hit = (flags[TfStar] & t[TbStar]) | (flags[TfWind] & t[TbWind]) |
              (flags[TfGas] & t[TbGas]);
    if (flags[TfAllBaryon] && flags[TfAllDm]) begin
      res = 1'b1;
    end else if (flags[TfAllDm]) begin
      res = sel_hit | ~t[TbBaryon];
    end else if (flags[TfAllBaryon]) begin
      res = t[TbBaryon] | (flags[TfNucleus] & t[TbNucleus]);
    end else begin
      res = sel_hit | (flags[TfNucleus] & t[TbNucleus]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/psf_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// psf_cfg_regs: configuration register file
// Decodes write transfers into the filter settings; interval ends are stored
// already ordered as low and high bound.
// ---------------------------------------------------------------------------
`default_nettype none

module psf_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [psf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [psf_pkg::CfgDataW-1:0]  cfg_data_i,
  output      psf_pkg::cfg_t                 cfg_o
);

  psf_pkg::cfg_t cfg_d, cfg_q;
  logic signed [psf_pkg::ScalarW-1:0] bnd_a, bnd_b;

  assign cfg_ready_o = 1'b1;
  assign bnd_a = cfg_data_i[psf_pkg::ScalarW-1:0];
  assign bnd_b = cfg_data_i[2*psf_pkg::ScalarW-1:psf_pkg::ScalarW];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        psf_pkg::RegFilterMode:   cfg_d.filter_mode = cfg_data_i[2:0];
        psf_pkg::RegControlFlags: begin
          cfg_d.and_mode = cfg_data_i[0];
          cfg_d.invert   = cfg_data_i[1];
        end
        psf_pkg::RegTypeFlags:    cfg_d.type_flags = cfg_data_i[5:0];
        psf_pkg::RegIntervalAttr: cfg_d.interval_attr = cfg_data_i[2:0];
        psf_pkg::RegRefPoint:     cfg_d.ref_point = cfg_data_i[3*psf_pkg::CoordW-1:0];
        psf_pkg::RegNormalVector: cfg_d.normal_vector = cfg_data_i[3*psf_pkg::CoordW-1:0];
        psf_pkg::RegRadiusSq:     cfg_d.radius_sq = cfg_data_i[psf_pkg::RadiusW-1:0];
        psf_pkg::RegIntervalBnd: begin
          if (bnd_a < bnd_b) begin
            cfg_d.interval_lo = bnd_a;
            cfg_d.interval_hi = bnd_b;
          end else begin
            cfg_d.interval_lo = bnd_b;
            cfg_d.interval_hi = bnd_a;
          end
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/particle_selection_filter_top.sv @@
// ---------------------------------------------------------------------------
// particle_selection_filter_top: per-particle enable filter
// Four-stage pipeline: operand select, shared multiply, sum, compare and
// combine with the prior enable bit.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start_i / busy_o       particle_id_i .. prior_enabled_i
//  result    done_o (strobe)        result_id_o, enabled_out_o
//  config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One particle per cycle; done_o and the result come from the stage-4
//  registers, behind the stage-1, stage-2 and stage-3 registers.
//  The three 17x17 multipliers are shared by plane, sphere and squared speed.
//  Reset clears the stage valid bits and the configuration registers; the
//  data registers are not reset.
//  busy_o stays low: the pipeline never stalls, results are not held.
// ---------------------------------------------------------------------------
`default_nettype none

module particle_selection_filter_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output      logic                                busy_o,
  input  wire logic [psf_pkg::IdW-1:0]             particle_id_i,
  input  wire logic [psf_pkg::TypeW-1:0]           type_bits_i,
  input  wire logic signed [psf_pkg::CoordW-1:0]   pos_x_i,
  input  wire logic signed [psf_pkg::CoordW-1:0]   pos_y_i,
  input  wire logic signed [psf_pkg::CoordW-1:0]   pos_z_i,
  input  wire logic signed [psf_pkg::CoordW-1:0]   vel_x_i,
  input  wire logic signed [psf_pkg::CoordW-1:0]   vel_y_i,
  input  wire logic signed [psf_pkg::CoordW-1:0]   vel_z_i,
  input  wire logic signed [psf_pkg::ScalarW-1:0]  scalar_value_i,
  input  wire logic                                prior_enabled_i,
  output      logic                                done_o,
  output      logic [psf_pkg::IdW-1:0]             result_id_o,
  output      logic                                enabled_out_o,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [psf_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [psf_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned CW = psf_pkg::CoordW;
  localparam int unsigned DW = psf_pkg::DiffW;
  localparam int unsigned PW = psf_pkg::ProdW;
  localparam int unsigned SW = psf_pkg::SumW;
  localparam int unsigned VW = psf_pkg::ScalarW;

  psf_pkg::cfg_t cfg;

  psf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------- stage 1: operand select
  logic signed [CW-1:0] pos [3];
  logic signed [CW-1:0] vel [3];
  logic signed [CW-1:0] refc [3];
  logic signed [CW-1:0] nrm [3];
  logic signed [DW-1:0] diff [3];
  logic signed [DW-1:0] op_a_d [3];
  logic signed [DW-1:0] op_b_d [3];
  logic signed [DW-1:0] op_a_q [3];
  logic signed [DW-1:0] op_b_q [3];
  logic signed [VW-1:0] ival1_d, ival1_q;
  logic                 s1_valid_q;
  logic [psf_pkg::IdW-1:0] s1_id_q;
  logic                 s1_prior_q, s1_type_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign vel[0] = vel_x_i;
  assign vel[1] = vel_y_i;
  assign vel[2] = vel_z_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      refc[k] = cfg.ref_point[k*CW +: CW];
      nrm[k]  = cfg.normal_vector[k*CW +: CW];
      diff[k] = DW'(pos[k]) - DW'(refc[k]);
      case (cfg.filter_mode)
        psf_pkg::ModePlane: begin
          op_a_d[k] = diff[k];
          op_b_d[k] = DW'(nrm[k]);
        end
        psf_pkg::ModeSphere: begin
          op_a_d[k] = diff[k];
          op_b_d[k] = diff[k];
        end
        default: begin
          op_a_d[k] = DW'(vel[k]);
          op_b_d[k] = DW'(vel[k]);
        end
      endcase
    end
  end

  always_comb begin
    case (cfg.interval_attr)
      psf_pkg::AttrPosX:   ival1_d = VW'(pos_x_i);
      psf_pkg::AttrPosY:   ival1_d = VW'(pos_y_i);
      psf_pkg::AttrPosZ:   ival1_d = VW'(pos_z_i);
      psf_pkg::AttrVelX:   ival1_d = VW'(vel_x_i);
      psf_pkg::AttrVelY:   ival1_d = VW'(vel_y_i);
      psf_pkg::AttrVelZ:   ival1_d = VW'(vel_z_i);
      psf_pkg::AttrScalar: ival1_d = scalar_value_i;
      default:             ival1_d = '0; // squared speed comes from the sum
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_id_q    <= particle_id_i;
    s1_prior_q <= prior_enabled_i;
    s1_type_q  <= psf_pkg::type_hit(cfg.type_flags, type_bits_i);
    ival1_q    <= ival1_d;
    for (int k = 0; k < 3; k++) begin
      op_a_q[k] <= op_a_d[k];
      op_b_q[k] <= op_b_d[k];
    end
  end

  // ---------------- stage 2: products
  logic signed [PW-1:0] prod_d [3];
  logic signed [PW-1:0] prod_q [3];
  logic                 s2_valid_q;
  logic [psf_pkg::IdW-1:0] s2_id_q;
  logic                 s2_prior_q, s2_type_q;
  logic signed [VW-1:0] ival2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = PW'(op_a_q[k]) * PW'(op_b_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_id_q    <= s1_id_q;
    s2_prior_q <= s1_prior_q;
    s2_type_q  <= s1_type_q;
    ival2_q    <= ival1_q;
    for (int k = 0; k < 3; k++) begin
      prod_q[k] <= prod_d[k];
    end
  end

  // ---------------- stage 3: sum
  logic signed [SW-1:0] sum_d, sum_q;
  logic                 s3_valid_q;
  logic [psf_pkg::IdW-1:0] s3_id_q;
  logic                 s3_prior_q, s3_type_q;
  logic signed [VW-1:0] ival3_q;

  assign sum_d = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_id_q    <= s2_id_q;
    s3_prior_q <= s2_prior_q;
    s3_type_q  <= s2_type_q;
    ival3_q    <= ival2_q;
    sum_q      <= sum_d;
  end

  // ---------------- stage 4: compare and combine
  logic signed [VW-1:0] speed2;
  logic signed [VW-1:0] ival;
  logic signed [SW-1:0] radius_ext;
  logic                 test;
  logic                 enabled_d, enabled_q;
  logic                 done_q;
  logic [psf_pkg::IdW-1:0] result_id_q;

  assign speed2 = (sum_q > SW'(psf_pkg::Speed2Max)) ? psf_pkg::Speed2Max : sum_q[VW-1:0];
  assign ival   = (cfg.interval_attr == psf_pkg::AttrSpeed2) ? speed2 : ival3_q;
  assign radius_ext = SW'({1'b0, cfg.radius_sq});

  always_comb begin
    case (cfg.filter_mode)
      psf_pkg::ModeTypeMask: test = s3_type_q;
      // dot product not above zero: negative or exactly zero
      psf_pkg::ModePlane:    test = sum_q[SW-1] | (sum_q == '0);
      psf_pkg::ModeInterval: test = (cfg.interval_lo <= ival) && (ival <= cfg.interval_hi);
      psf_pkg::ModeSphere:   test = sum_q <= radius_ext;
      default:               test = 1'b0;
    endcase
    if (cfg.and_mode) begin
      enabled_d = s3_prior_q & (test ^ cfg.invert);
    end else begin
      enabled_d = s3_prior_q | test;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_id_q <= s3_id_q;
    enabled_q   <= enabled_d;
  end

  assign done_o        = done_q;
  assign result_id_o   = result_id_q;
  assign enabled_out_o = enabled_q;

endmodule

`default_nettype wire
